>>> hw/rtl/mstw_pkg.sv
package mstw_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TICK_W    = 32;
  localparam int LIMIT_W   = 31;
  localparam int MISS_W    = 2;
  localparam int MASK_W    = 8;
  localparam int OUT_IDX_W = 3;

  localparam logic [MISS_W-1:0] MISS_LIMIT_RST = MISS_W'(2);

  typedef enum logic [1:0] {
    MODE_REGISTER = 2'd0,
    MODE_FEED     = 2'd1,
    MODE_CHECK    = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_REG_SCAN,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              refresh;
    logic              warn;
    logic              hung;
    logic [MISS_W-1:0] miss_next;
  } slot_verdict_t;

  function automatic logic [OUT_IDX_W-1:0] slot_lo3(input logic [IDX_W-1:0] idx);
    logic [31:0] ext;
    ext = 32'(idx);
    return ext[OUT_IDX_W-1:0];
  endfunction

  function automatic logic slot_low_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(MASK_W);
  endfunction

endpackage

>>> hw/rtl/mstw_slot_eval.sv
module mstw_slot_eval (
  input  logic [mstw_pkg::TICK_W-1:0]  now_tick,
  input  logic [mstw_pkg::TICK_W-1:0]  last_tick,
  input  logic [mstw_pkg::LIMIT_W-1:0] limit,
  input  logic                         waiting_ok,
  input  logic                         waiting,
  input  logic [mstw_pkg::MISS_W-1:0]  miss,
  input  logic [mstw_pkg::MISS_W-1:0]  miss_limit,
  output mstw_pkg::slot_verdict_t      verdict
);
  import mstw_pkg::*;

  logic [TICK_W-1:0] age;
  logic              fresh;
  logic              failed;
  logic [MISS_W-1:0] miss_inc;

  assign age      = now_tick - last_tick;
  assign fresh    = age[TICK_W-1] || (age[LIMIT_W-1:0] <= limit);
  assign miss_inc = miss + MISS_W'(1);
  assign failed   = !fresh && !(waiting_ok && waiting);

  always_comb begin
    verdict.refresh   = !fresh && waiting_ok && waiting;
    verdict.miss_next = failed ? miss_inc : '0;
    verdict.hung      = failed && (miss_inc >= miss_limit);
    verdict.warn      = failed && (miss_inc < miss_limit);
  end

endmodule

>>> hw/rtl/multi_slot_task_watchdog_unit.sv
// Watchdog over NUM_SLOTS task slots. One beat is taken at a time; in_stall is high
// while a beat is in work. A register beat scans slots from 0, one per cycle, for the
// first free one. A check beat walks every slot, one per cycle, through a single age
// subtract-and-compare unit, and stops early when a hung slot raises a restart. Feed
// and unknown modes go from dispatch straight to finish, with no slot walk.
// A result sits in an output register, so the next beat is taken while it waits.
// miss_limit is written through cfg_wr_en/cfg_wr_data and resets to 2.
module multi_slot_task_watchdog_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [mstw_pkg::MISS_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic [mstw_pkg::TICK_W-1:0]  now_tick,
  input  logic [2:0]                   slot,
  input  logic [mstw_pkg::LIMIT_W-1:0] silence_limit_ticks,
  input  logic                         allow_waiting,
  input  logic [mstw_pkg::MASK_W-1:0]  waiting_mask,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   slot_given,
  output logic                         table_full,
  output logic [mstw_pkg::MASK_W-1:0]  warn_mask,
  output logic                         restart,
  output logic [2:0]                   hung_slot
);
  import mstw_pkg::*;

  state_t state, state_next;

  logic [MISS_W-1:0]  miss_limit;
  logic [NUM_SLOTS-1:0] slot_used;
  logic [TICK_W-1:0]  last_sign_of_life [NUM_SLOTS];
  logic [LIMIT_W-1:0] silence_limit     [NUM_SLOTS];
  logic               waiting_ok        [NUM_SLOTS];
  logic [MISS_W-1:0]  miss_count        [NUM_SLOTS];

  mode_t              mode_q;
  logic [TICK_W-1:0]  now_q;
  logic [2:0]         slot_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               allow_q;
  logic [MASK_W-1:0]  wmask_q;

  logic [IDX_W-1:0]   idx;
  logic               idx_last;
  logic [IDX_W-1:0]   feed_idx;
  logic               feed_ok;

  logic [2:0]         res_given;
  logic               res_full;
  logic [MASK_W-1:0]  res_warn;
  logic               res_restart;
  logic [2:0]         res_hung;

  logic               in_take;
  logic               out_load;
  logic               cur_waiting;
  slot_verdict_t      verdict;

  assign in_take  = in_valid && !in_stall;
  assign idx_last = (idx == IDX_W'(NUM_SLOTS - 1));
  assign feed_idx = IDX_W'(slot_q);
  assign feed_ok  = (32'(slot_q) < 32'(NUM_SLOTS)) && slot_used[feed_idx];
  assign cur_waiting = slot_low_range(idx) && wmask_q[slot_lo3(idx)];

  mstw_slot_eval u_eval (
    .now_tick   (now_q),
    .last_tick  (last_sign_of_life[idx]),
    .limit      (silence_limit[idx]),
    .waiting_ok (waiting_ok[idx]),
    .waiting    (cur_waiting),
    .miss       (miss_count[idx]),
    .miss_limit (miss_limit),
    .verdict    (verdict)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (mode_q)
          MODE_REGISTER: state_next = ST_REG_SCAN;
          MODE_CHECK:    state_next = ST_CHECK;
          default:       state_next = ST_FINISH;
        endcase
      end
      ST_REG_SCAN: begin
        if (!slot_used[idx] || idx_last) state_next = ST_FINISH;
      end
      ST_CHECK: begin
        if ((slot_used[idx] && verdict.hung) || idx_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    out_load = (state == ST_FINISH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_limit <= MISS_LIMIT_RST;
    end else if (cfg_wr_en) begin
      miss_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_q  <= mode_t'(mode);
      now_q   <= now_tick;
      slot_q  <= slot;
      limit_q <= silence_limit_ticks;
      allow_q <= allow_waiting;
      wmask_q <= waiting_mask;
    end
  end

  // sequencer datapath: one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx         <= '0;
          res_given   <= '0;
          res_full    <= 1'b0;
          res_warn    <= '0;
          res_restart <= 1'b0;
          res_hung    <= '0;
        end
        ST_DISPATCH: begin
          if (mode_q == MODE_FEED && feed_ok) begin
            last_sign_of_life[feed_idx] <= now_q;
          end
        end
        ST_REG_SCAN: begin
          if (!slot_used[idx]) begin
            slot_used[idx]         <= 1'b1;
            last_sign_of_life[idx] <= now_q;
            silence_limit[idx]     <= limit_q;
            waiting_ok[idx]        <= allow_q;
            miss_count[idx]        <= '0;
            res_given              <= slot_lo3(idx);
          end else if (idx_last) begin
            res_full <= 1'b1;
          end
          idx <= idx + IDX_W'(1);
        end
        ST_CHECK: begin
          if (slot_used[idx]) begin
            miss_count[idx] <= verdict.miss_next;
            if (verdict.refresh) last_sign_of_life[idx] <= now_q;
            if (verdict.warn && slot_low_range(idx)) res_warn[slot_lo3(idx)] <= 1'b1;
            if (verdict.hung) begin
              slot_used   <= '0;
              res_restart <= 1'b1;
              res_hung    <= slot_lo3(idx);
            end
          end
          idx <= idx + IDX_W'(1);
        end
        ST_FINISH: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slot_given <= res_given;
      table_full <= res_full;
      warn_mask  <= res_warn;
      restart    <= res_restart;
      hung_slot  <= res_hung;
    end
  end

`ifndef ASSERT_OFF
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input taken while a beat is in work");

  a_restart_not_warned: assert property (@(posedge clk) disable iff (rst)
    (out_valid && restart) |-> !warn_mask[hung_slot])
    else $error("hung slot also flagged as warning");

  a_check_result_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (restart || warn_mask != '0)) |-> (!table_full && slot_given == '0))
    else $error("check result carries register fields");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> (slot_given == '0 && warn_mask == '0 && !restart))
    else $error("full result carries other fields");
`endif

endmodule
